@@ src/pwts_pkg.sv @@
// Shared types and constants for the per-port window traffic statistics block
`timescale 1ns / 1ps
package pwts_pkg;
    localparam int CMD_W      = 2;
    localparam int PORT_W     = 3;
    localparam int TS_W       = 48;
    localparam int SIZE_W     = 16;
    localparam int CNT_W      = 32;
    localparam int BYTE_W     = 48;
    localparam int GSQ_W      = 64;
    localparam int CV_W       = 24;
    localparam int MAX_PORTS  = 8;
    localparam int MUL_W      = 64;
    localparam int PROD_W     = 128;
    localparam int DIV_REM_W  = 104;
    localparam int DIV_DVD_W  = 48;
    localparam int DIV_STEP_W = 6;

    localparam logic [CMD_W-1:0] CMD_ENQ    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DROP   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd3;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic                  start;
        logic [DIV_REM_W-1:0]  rem;
        logic [DIV_REM_W-1:0]  divisor;
        logic [DIV_DVD_W-1:0]  dividend;
        logic [DIV_STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_DVD_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic [PORT_W-1:0] report_port;
        logic              last_row;
        logic [CNT_W-1:0]  enq_packets;
        logic [BYTE_W-1:0] enq_bytes;
        logic [TS_W-1:0]   enq_mean_gap;
        logic [CV_W-1:0]   enq_gap_cv2;
        logic [CNT_W-1:0]  deq_packets;
        logic [BYTE_W-1:0] deq_bytes;
        logic [TS_W-1:0]   deq_mean_gap;
        logic [CV_W-1:0]   deq_gap_cv2;
        logic [CNT_W-1:0]  drop_packets;
        logic [BYTE_W-1:0] drop_bytes;
    } t_row;
endpackage

@@ src/pwts_ifs.sv @@
// Channel interfaces: event input, configuration write, report row output
`timescale 1ns / 1ps
interface pwts_evt_if;
    import pwts_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [PORT_W-1:0] port;
    logic [TS_W-1:0]   timestamp_ns;
    logic [SIZE_W-1:0] packet_size;
    modport source(output valid, command, port, timestamp_ns, packet_size, input ready);
    modport sink(input valid, command, port, timestamp_ns, packet_size, output ready);
endinterface

interface pwts_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] port_enable;
    modport source(output valid, port_enable, input ready);
    modport sink(input valid, port_enable, output ready);
endinterface

interface pwts_row_if;
    import pwts_pkg::*;
    logic              valid;
    logic              ready;
    logic [PORT_W-1:0] report_port;
    logic              last_row;
    logic [CNT_W-1:0]  enq_packets;
    logic [BYTE_W-1:0] enq_bytes;
    logic [TS_W-1:0]   enq_mean_gap;
    logic [CV_W-1:0]   enq_gap_cv2;
    logic [CNT_W-1:0]  deq_packets;
    logic [BYTE_W-1:0] deq_bytes;
    logic [TS_W-1:0]   deq_mean_gap;
    logic [CV_W-1:0]   deq_gap_cv2;
    logic [CNT_W-1:0]  drop_packets;
    logic [BYTE_W-1:0] drop_bytes;
    modport source(output valid, report_port, last_row, enq_packets, enq_bytes, enq_mean_gap,
                   enq_gap_cv2, deq_packets, deq_bytes, deq_mean_gap, deq_gap_cv2,
                   drop_packets, drop_bytes, input ready);
    modport sink(input valid, report_port, last_row, enq_packets, enq_bytes, enq_mean_gap,
                 enq_gap_cv2, deq_packets, deq_bytes, deq_mean_gap, deq_gap_cv2,
                 drop_packets, drop_bytes, output ready);
endinterface

@@ src/pwts_mul.sv @@
// Sequential 64x64 multiplier built from four 32x32 partial products
`timescale 1ns / 1ps
module pwts_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pwts_pkg::t_mul_req i_req,
    output pwts_pkg::t_mul_rsp o_rsp
);
    import pwts_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [2:0]        r_step;
    logic [MUL_W-1:0]  r_a;
    logic [MUL_W-1:0]  r_b;
    logic [MUL_W-1:0]  r_pp;
    logic [1:0]        r_pp_sh;
    logic              r_pp_vld;
    logic [PROD_W-1:0] r_acc;

    logic [31:0]       w_a_part;
    logic [31:0]       w_b_part;
    logic [PROD_W-1:0] w_pp_ext;

    assign w_a_part = r_step[1] ? r_a[63:32] : r_a[31:0];
    assign w_b_part = r_step[0] ? r_b[63:32] : r_b[31:0];
    assign w_pp_ext = {64'd0, r_pp} << {r_pp_sh, 5'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_step   <= '0;
            r_pp_vld <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy   <= 1'b1;
                r_step   <= '0;
                r_pp_vld <= 1'b0;
            end else if (r_busy) begin
                r_pp_vld <= (r_step < 3'd4);
                r_step   <= r_step + 3'd1;
                if (r_step == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_pp    <= 64'(w_a_part * w_b_part);
            r_pp_sh <= {1'b0, r_step[1]} + {1'b0, r_step[0]};
            if (r_pp_vld) begin
                r_acc <= r_acc + w_pp_ext;
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;
endmodule

@@ src/pwts_div.sv @@
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pwts_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pwts_pkg::t_div_req i_req,
    output pwts_pkg::t_div_rsp o_rsp
);
    import pwts_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic [DIV_REM_W-1:0]  r_rem;
    logic [DIV_REM_W-1:0]  r_div;
    logic [DIV_DVD_W-1:0]  r_dvd;
    logic [DIV_DVD_W-1:0]  r_q;

    logic [DIV_REM_W:0]    w_t;
    logic [DIV_REM_W:0]    w_diff;
    logic                  w_ge;

    assign w_t    = {r_rem, r_dvd[DIV_DVD_W-1]};
    assign w_ge   = (w_t >= {1'b0, r_div});
    assign w_diff = w_t - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_div <= i_req.divisor;
            r_dvd <= i_req.dividend;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_REM_W-1:0] : w_t[DIV_REM_W-1:0];
            r_dvd <= {r_dvd[DIV_DVD_W-2:0], 1'b0};
            r_q   <= {r_q[DIV_DVD_W-2:0], w_ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
endmodule

@@ src/per_port_window_traffic_stats.sv @@
// Top level: per-port window traffic statistics with a shared multiply/divide datapath
// Events: a drop is counted in S_IDLE; enqueue/dequeue pass through S_EGAP, and S_EMUL
//   when a gap is squared.
// Throughput: one transaction at a time; the shared 32x32 multiplier and the bit-serial
//   divider set the report time, and S_SCAN steps past each disabled port.
// Reset: synchronous active-low i_rst_n clears port_enable and all per-port window state.
`timescale 1ns / 1ps
module per_port_window_traffic_stats #(
    parameter int NUM_PORTS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pwts_evt_if.sink   i_evt,
    pwts_cfg_if.sink   i_cfg,
    pwts_row_if.source o_row
);
    import pwts_pkg::*;

    // Only eight ports are addressable by the port field
    localparam int NP = (NUM_PORTS < MAX_PORTS) ? NUM_PORTS : MAX_PORTS;
    localparam int PW = (NP > 1) ? $clog2(NP) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EGAP = 4'd1;   // event: gap compute / base update
    localparam logic [3:0] S_EMUL = 4'd2;   // event: waiting on gap square
    localparam logic [3:0] S_SCAN = 4'd3;   // report: find next enabled port
    localparam logic [3:0] S_KIND = 4'd4;   // report: start enq or deq stats
    localparam logic [3:0] S_MEAN = 4'd5;   // report: gap_sum / gaps
    localparam logic [3:0] S_MULN = 4'd6;   // report: gaps * sq_sum
    localparam logic [3:0] S_MULD = 4'd7;   // report: gap_sum^2
    localparam logic [3:0] S_CHK  = 4'd8;   // report: sign and saturation checks
    localparam logic [3:0] S_CV   = 4'd9;   // report: cv2 fraction division
    localparam logic [3:0] S_EMIT = 4'd10;  // report: load output row, clear port

    // Configuration
    logic [7:0] r_enable;

    // Per-port window state, index 0 = enqueue, 1 = dequeue
    logic [TS_W-1:0]   r_prev_time  [2][NP];
    logic              r_prev_valid [2][NP];
    logic [CNT_W-1:0]  r_cnt        [2][NP];
    logic [BYTE_W-1:0] r_bytes      [2][NP];
    logic [TS_W-1:0]   r_gsum       [2][NP];
    logic [GSQ_W-1:0]  r_gsq        [2][NP];
    logic [CNT_W-1:0]  r_drop_cnt   [NP];
    logic [BYTE_W-1:0] r_drop_bytes [NP];

    // Sequencer and working registers
    logic [3:0]        r_state, n_state;
    logic [PORT_W-1:0] r_port, n_port;
    logic              r_kind, n_kind;
    logic [TS_W-1:0]   r_ts;
    logic [SIZE_W-1:0] r_size;
    logic [95:0]       r_num;
    logic [95:0]       r_den;
    logic [TS_W-1:0]   r_mean [2];
    logic [CV_W-1:0]   r_cv   [2];
    logic              r_out_valid;
    t_row              r_row;

    t_mul_req w_mul_req;
    t_mul_rsp w_mul_rsp;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic [MAX_PORTS-1:0] w_mask;
    logic [8:0]           w_le;
    logic                 w_last;
    logic [PW-1:0]        w_pi;
    logic [PW-1:0]        w_dpi;
    logic                 w_acc;

    logic [TS_W-1:0]   w_prev_time;
    logic              w_prev_valid;
    logic [CNT_W-1:0]  w_cnt;
    logic [BYTE_W-1:0] w_bytes;
    logic [TS_W-1:0]   w_gsum;
    logic [GSQ_W-1:0]  w_gsq;
    logic [CNT_W-1:0]  w_gaps;
    logic [TS_W-1:0]   w_gap;

    logic [CNT_W-1:0]  w_cnt_inc;
    logic [BYTE_W:0]   w_bytes_sum;
    logic [BYTE_W-1:0] w_bytes_sat;
    logic [TS_W:0]     w_gsum_sum;
    logic [TS_W-1:0]   w_gsum_sat;
    logic [GSQ_W-1:0]  w_sq;
    logic [GSQ_W:0]    w_gsq_sum;
    logic [GSQ_W-1:0]  w_gsq_sat;
    logic [CNT_W-1:0]  w_dcnt;
    logic [CNT_W-1:0]  w_dcnt_inc;
    logic [BYTE_W-1:0] w_dbytes;
    logic [BYTE_W:0]   w_dbytes_sum;
    logic [BYTE_W-1:0] w_dbytes_sat;

    logic [95:0]       w_r;
    logic [103:0]      w_t;
    logic              w_num_lt;
    logic              w_cv_sat;

    logic              w_upd_base;
    logic              w_upd_gap;
    logic              w_drop;
    logic              w_clear;
    logic              w_mean_we;
    logic [TS_W-1:0]   w_mean_val;
    logic              w_cv_we;
    logic [CV_W-1:0]   w_cv_val;
    logic              w_num_we;
    logic              w_den_we;
    logic              w_kind_done;

    genvar g;
    generate
        for (g = 0; g < MAX_PORTS; g++) begin : g_mask
            assign w_mask[g] = (g < NP) && r_enable[g];
        end
    endgenerate

    // Last row: no enabled port above the current one
    assign w_le   = (9'd2 << r_port) - 9'd1;
    assign w_last = ((w_mask & ~w_le[7:0]) == '0);

    assign w_pi  = r_port[PW-1:0];
    assign w_dpi = i_evt.port[PW-1:0];
    assign w_acc = i_evt.valid && i_evt.ready;

    assign w_prev_time  = r_prev_time[r_kind][w_pi];
    assign w_prev_valid = r_prev_valid[r_kind][w_pi];
    assign w_cnt        = r_cnt[r_kind][w_pi];
    assign w_bytes      = r_bytes[r_kind][w_pi];
    assign w_gsum       = r_gsum[r_kind][w_pi];
    assign w_gsq        = r_gsq[r_kind][w_pi];
    assign w_gaps       = (w_cnt == '0) ? '0 : w_cnt - 1'b1;
    // A decreasing timestamp counts as a zero gap
    assign w_gap        = (r_ts >= w_prev_time) ? r_ts - w_prev_time : '0;

    // Saturating updates
    assign w_cnt_inc   = (&w_cnt) ? w_cnt : w_cnt + 1'b1;
    assign w_bytes_sum = {1'b0, w_bytes} + {{(BYTE_W-SIZE_W+1){1'b0}}, r_size};
    assign w_bytes_sat = w_bytes_sum[BYTE_W] ? '1 : w_bytes_sum[BYTE_W-1:0];
    assign w_gsum_sum  = {1'b0, w_gsum} + {1'b0, w_gap};
    assign w_gsum_sat  = w_gsum_sum[TS_W] ? '1 : w_gsum_sum[TS_W-1:0];
    assign w_sq        = (w_mul_rsp.prod[PROD_W-1:GSQ_W] != '0) ? '1
                                                               : w_mul_rsp.prod[GSQ_W-1:0];
    assign w_gsq_sum   = {1'b0, w_gsq} + {1'b0, w_sq};
    assign w_gsq_sat   = w_gsq_sum[GSQ_W] ? '1 : w_gsq_sum[GSQ_W-1:0];

    assign w_dcnt       = r_drop_cnt[w_dpi];
    assign w_dbytes     = r_drop_bytes[w_dpi];
    assign w_dcnt_inc   = (&w_dcnt) ? w_dcnt : w_dcnt + 1'b1;
    assign w_dbytes_sum = {1'b0, w_dbytes}
                        + {{(BYTE_W-SIZE_W+1){1'b0}}, i_evt.packet_size};
    assign w_dbytes_sat = w_dbytes_sum[BYTE_W] ? '1 : w_dbytes_sum[BYTE_W-1:0];

    // cv2 = (gaps*sq - sum^2) * 2^16 / sum^2, saturated once it reaches 256.0
    assign w_num_lt = (r_num < r_den);
    assign w_r      = r_num - r_den;
    assign w_t      = {r_den, 8'd0};
    assign w_cv_sat = ({8'd0, w_r} >= w_t);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_port      = r_port;
        n_kind      = r_kind;
        w_mul_req   = '0;
        w_div_req   = '0;
        w_upd_base  = 1'b0;
        w_upd_gap   = 1'b0;
        w_drop      = 1'b0;
        w_clear     = 1'b0;
        w_mean_we   = 1'b0;
        w_mean_val  = '0;
        w_cv_we     = 1'b0;
        w_cv_val    = '0;
        w_num_we    = 1'b0;
        w_den_we    = 1'b0;
        w_kind_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_kind = (i_evt.command == CMD_DEQ);
                    n_port = i_evt.port;
                    if (i_evt.command == CMD_REPORT) begin
                        n_port  = '0;
                        n_state = S_SCAN;
                    end else if (w_mask[i_evt.port]) begin
                        if (i_evt.command == CMD_DROP) begin
                            w_drop = 1'b1;
                        end else begin
                            n_state = S_EGAP;
                        end
                    end
                end
            end
            S_EGAP: begin
                if (w_prev_valid) begin
                    w_mul_req.start = 1'b1;
                    w_mul_req.a     = {16'd0, w_gap};
                    w_mul_req.b     = {16'd0, w_gap};
                    n_state         = S_EMUL;
                end else begin
                    w_upd_base = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_EMUL: begin
                if (w_mul_rsp.done) begin
                    w_upd_base = 1'b1;
                    w_upd_gap  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SCAN: begin
                if (w_mask[r_port]) begin
                    n_kind  = 1'b0;
                    n_state = S_KIND;
                end else if (r_port == PORT_W'(NP - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_port = r_port + 1'b1;
                end
            end
            S_KIND: begin
                if (w_gaps == '0) begin
                    w_mean_we   = 1'b1;
                    w_cv_we     = 1'b1;
                    w_kind_done = 1'b1;
                end else begin
                    w_div_req.start    = 1'b1;
                    w_div_req.divisor  = {{(DIV_REM_W-CNT_W){1'b0}}, w_gaps};
                    w_div_req.dividend = w_gsum;
                    w_div_req.steps    = DIV_STEP_W'(DIV_DVD_W);
                    n_state            = S_MEAN;
                end
            end
            S_MEAN: begin
                if (w_div_rsp.done) begin
                    w_mean_we  = 1'b1;
                    w_mean_val = w_div_rsp.quot;
                    if (w_gsum == '0) begin
                        w_cv_we     = 1'b1;
                        w_kind_done = 1'b1;
                    end else begin
                        w_mul_req.start = 1'b1;
                        w_mul_req.a     = {32'd0, w_gaps};
                        w_mul_req.b     = w_gsq;
                        n_state         = S_MULN;
                    end
                end
            end
            S_MULN: begin
                if (w_mul_rsp.done) begin
                    w_num_we        = 1'b1;
                    w_mul_req.start = 1'b1;
                    w_mul_req.a     = {16'd0, w_gsum};
                    w_mul_req.b     = {16'd0, w_gsum};
                    n_state         = S_MULD;
                end
            end
            S_MULD: begin
                if (w_mul_rsp.done) begin
                    w_den_we = 1'b1;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (w_num_lt) begin
                    w_cv_we     = 1'b1;
                    w_kind_done = 1'b1;
                end else if (w_cv_sat) begin
                    w_cv_we     = 1'b1;
                    w_cv_val    = '1;
                    w_kind_done = 1'b1;
                end else begin
                    w_div_req.start   = 1'b1;
                    w_div_req.rem     = {8'd0, w_r};
                    w_div_req.divisor = w_t;
                    w_div_req.steps   = DIV_STEP_W'(CV_W);
                    n_state           = S_CV;
                end
            end
            S_CV: begin
                if (w_div_rsp.done) begin
                    w_cv_we     = 1'b1;
                    w_cv_val    = w_div_rsp.quot[CV_W-1:0];
                    w_kind_done = 1'b1;
                end
            end
            S_EMIT: begin
                if (!r_out_valid) begin
                    w_clear = 1'b1;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_port  = r_port + 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_kind_done) begin
            if (!r_kind) begin
                n_kind  = 1'b1;
                n_state = S_KIND;
            end else begin
                n_state = S_EMIT;
            end
        end
    end

    pwts_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    pwts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_port      <= '0;
            r_kind      <= 1'b0;
            r_enable    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_port  <= n_port;
            r_kind  <= n_kind;
            if (i_cfg.valid && i_cfg.ready) begin
                r_enable <= i_cfg.port_enable;
            end
            if (w_clear) begin
                r_out_valid <= 1'b1;
            end else if (o_row.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and output payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ts   <= i_evt.timestamp_ns;
            r_size <= i_evt.packet_size;
        end
        if (w_num_we) begin
            r_num <= w_mul_rsp.prod[95:0];
        end
        if (w_den_we) begin
            r_den <= w_mul_rsp.prod[95:0];
        end
        if (w_mean_we) begin
            r_mean[r_kind] <= w_mean_val;
        end
        if (w_cv_we) begin
            r_cv[r_kind] <= w_cv_val;
        end
        if (w_clear) begin
            r_row.report_port  <= r_port;
            r_row.last_row     <= w_last;
            r_row.enq_packets  <= r_cnt[0][w_pi];
            r_row.enq_bytes    <= r_bytes[0][w_pi];
            r_row.enq_mean_gap <= r_mean[0];
            r_row.enq_gap_cv2  <= r_cv[0];
            r_row.deq_packets  <= r_cnt[1][w_pi];
            r_row.deq_bytes    <= r_bytes[1][w_pi];
            r_row.deq_mean_gap <= r_mean[1];
            r_row.deq_gap_cv2  <= r_cv[1];
            r_row.drop_packets <= r_drop_cnt[w_pi];
            r_row.drop_bytes   <= r_drop_bytes[w_pi];
        end
    end

    // Per-port window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NP; p++) begin
                for (int k = 0; k < 2; k++) begin
                    r_prev_time[k][p]  <= '0;
                    r_prev_valid[k][p] <= 1'b0;
                    r_cnt[k][p]        <= '0;
                    r_bytes[k][p]      <= '0;
                    r_gsum[k][p]       <= '0;
                    r_gsq[k][p]        <= '0;
                end
                r_drop_cnt[p]   <= '0;
                r_drop_bytes[p] <= '0;
            end
        end else begin
            if (w_clear) begin
                for (int k = 0; k < 2; k++) begin
                    r_prev_time[k][w_pi]  <= '0;
                    r_prev_valid[k][w_pi] <= 1'b0;
                    r_cnt[k][w_pi]        <= '0;
                    r_bytes[k][w_pi]      <= '0;
                    r_gsum[k][w_pi]       <= '0;
                    r_gsq[k][w_pi]        <= '0;
                end
                r_drop_cnt[w_pi]   <= '0;
                r_drop_bytes[w_pi] <= '0;
            end
            if (w_upd_base) begin
                r_prev_time[r_kind][w_pi]  <= r_ts;
                r_prev_valid[r_kind][w_pi] <= 1'b1;
                r_cnt[r_kind][w_pi]        <= w_cnt_inc;
                r_bytes[r_kind][w_pi]      <= w_bytes_sat;
            end
            if (w_upd_gap) begin
                r_gsum[r_kind][w_pi] <= w_gsum_sat;
                r_gsq[r_kind][w_pi]  <= w_gsq_sat;
            end
            if (w_drop) begin
                r_drop_cnt[w_dpi]   <= w_dcnt_inc;
                r_drop_bytes[w_dpi] <= w_dbytes_sat;
            end
        end
    end

    assign i_evt.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_row.valid        = r_out_valid;
    assign o_row.report_port  = r_row.report_port;
    assign o_row.last_row     = r_row.last_row;
    assign o_row.enq_packets  = r_row.enq_packets;
    assign o_row.enq_bytes    = r_row.enq_bytes;
    assign o_row.enq_mean_gap = r_row.enq_mean_gap;
    assign o_row.enq_gap_cv2  = r_row.enq_gap_cv2;
    assign o_row.deq_packets  = r_row.deq_packets;
    assign o_row.deq_bytes    = r_row.deq_bytes;
    assign o_row.deq_mean_gap = r_row.deq_mean_gap;
    assign o_row.deq_gap_cv2  = r_row.deq_gap_cv2;
    assign o_row.drop_packets = r_row.drop_packets;
    assign o_row.drop_bytes   = r_row.drop_bytes;

    // Shared units are idle whenever a new transaction can be taken
    a_idle_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!w_mul_rsp.busy && !w_div_rsp.busy))
        else $error("shared unit busy while idle");

    // Divider completions only land in the states that wait on them
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_MEAN || r_state == S_CV))
        else $error("unexpected divider completion");

    // Multiplier completions only land in the states that wait on them
    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_rsp.done |-> (r_state == S_EMUL || r_state == S_MULN || r_state == S_MULD))
        else $error("unexpected multiplier completion");

    // A row is only loaded once the previous one has been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |-> !r_out_valid)
        else $error("output row overwritten");
endmodule
